FILE: sv/svm_pkg.sv
// Shared types, codes and constants for the stack VM core.
package svm_pkg;

  localparam int MEM_WORDS_DEF = 1024;
  localparam int CODE_LIMIT    = 4096;
  localparam logic [12:0] STACK_TOP_RST = 13'd4096;

  typedef enum logic [1:0] {
    FN_WRITE = 2'd0,
    FN_READ  = 2'd1,
    FN_START = 2'd2,
    FN_EXEC  = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_EXIT    = 3'd1,
    ST_ILL     = 3'd2,
    ST_DIV0    = 3'd3,
    ST_BADADDR = 3'd4,
    ST_IDLE    = 3'd5
  } status_e;

  typedef enum logic [5:0] {
    OP_LEA  = 6'd0,  OP_IMM  = 6'd1,  OP_JMP  = 6'd2,  OP_CALL = 6'd3,
    OP_JZ   = 6'd4,  OP_JNZ  = 6'd5,  OP_ENT  = 6'd6,  OP_ADJ  = 6'd7,
    OP_LEV  = 6'd8,  OP_LI   = 6'd9,  OP_LC   = 6'd10, OP_SI   = 6'd11,
    OP_SC   = 6'd12, OP_PUSH = 6'd13, OP_OR   = 6'd14, OP_XOR  = 6'd15,
    OP_AND  = 6'd16, OP_EQ   = 6'd17, OP_NE   = 6'd18, OP_LT   = 6'd19,
    OP_GT   = 6'd20, OP_LE   = 6'd21, OP_GE   = 6'd22, OP_SHL  = 6'd23,
    OP_SHR  = 6'd24, OP_ADD  = 6'd25, OP_SUB  = 6'd26, OP_MUL  = 6'd27,
    OP_DIV  = 6'd28, OP_MOD  = 6'd29, OP_EXIT = 6'd37
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_RD, S_ST1, S_ST2, S_ST3, S_FETCH, S_IMM,
    S_EXEC, S_POP, S_LEV1, S_LEV2, S_LOAD, S_SCRD, S_DIV, S_OUT
  } state_e;

  typedef struct packed {
    logic [1:0]         func;
    logic [11:0]        addr;
    logic signed [31:0] data;
  } in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] accumulator_out;
    logic [11:0]        next_pc;
    logic signed [31:0] read_data;
  } out_t;

endpackage

FILE: sv/svm_ram.sv
// Generic single-port RAM with registered read.
module svm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

FILE: sv/svm_alu.sv
// Shared combinational ALU for the binary opcodes other than DIV and MOD.
module svm_alu (
  input  svm_pkg::op_e  op_i,
  input  logic [31:0]   l_i,
  input  logic [31:0]   r_i,
  output logic [31:0]   res_o
);
  import svm_pkg::*;
  logic lt_lr, lt_rl;

  always_comb begin
    lt_lr = $signed(l_i) < $signed(r_i);
    lt_rl = $signed(r_i) < $signed(l_i);
    case (op_i)
      OP_OR:   res_o = l_i | r_i;
      OP_XOR:  res_o = l_i ^ r_i;
      OP_AND:  res_o = l_i & r_i;
      OP_EQ:   res_o = {31'd0, l_i == r_i};
      OP_NE:   res_o = {31'd0, l_i != r_i};
      OP_LT:   res_o = {31'd0, lt_lr};
      OP_GT:   res_o = {31'd0, lt_rl};
      OP_LE:   res_o = {31'd0, !lt_rl};
      OP_GE:   res_o = {31'd0, !lt_lr};
      OP_SHL:  res_o = l_i << r_i[4:0];
      OP_SHR:  res_o = 32'($signed(l_i) >>> r_i[4:0]);
      OP_ADD:  res_o = l_i + r_i;
      OP_SUB:  res_o = l_i - r_i;
      OP_MUL:  res_o = l_i * r_i;
      default: res_o = l_i;
    endcase
  end
endmodule

FILE: sv/svm_div.sv
// Radix-2 restoring divider, signed truncating quotient or remainder.
module svm_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        rem_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic        done_o,
  output logic [31:0] res_o
);
  logic        busy_q, busy_d, done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [31:0] rem_q, rem_d, quo_q, quo_d, mb_q, mb_d, res_q, res_d;
  logic        na_q, na_d, nb_q, nb_d, want_q, want_d;
  logic [32:0] diff;

  always_comb begin
    busy_d = busy_q; done_d = 1'b0; cnt_d = cnt_q;
    rem_d = rem_q; quo_d = quo_q; mb_d = mb_q; res_d = res_q;
    na_d = na_q; nb_d = nb_q; want_d = want_q;
    diff = {rem_q, quo_q[31]} - {1'b0, mb_q};
    if (start_i) begin
      busy_d = 1'b1; cnt_d = '0; rem_d = '0;
      na_d = a_i[31]; nb_d = b_i[31]; want_d = rem_i;
      quo_d = a_i[31] ? 32'd0 - a_i : a_i;
      mb_d  = b_i[31] ? 32'd0 - b_i : b_i;
    end else if (busy_q) begin
      if (cnt_q == 6'd32) begin
        busy_d = 1'b0; done_d = 1'b1;
        if (want_q) res_d = na_q ? 32'd0 - rem_q : rem_q;
        else        res_d = (na_q ^ nb_q) ? 32'd0 - quo_q : quo_q;
      end else begin
        cnt_d = cnt_q + 6'd1;
        if (!diff[32]) begin
          rem_d = diff[31:0];
          quo_d = {quo_q[30:0], 1'b1};
        end else begin
          rem_d = {rem_q[30:0], quo_q[31]};
          quo_d = {quo_q[30:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; quo_q <= quo_d; mb_q <= mb_d; res_q <= res_d;
    na_q <= na_d; nb_q <= nb_d; want_q <= want_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;
endmodule

FILE: sv/stack_vm_core.sv
// Stack VM core: sequencer, registers, shared ALU and divider, unified memory.
// One item at a time: a single registered memory port serializes fetch,
// operand and stack accesses, and DIV and MOD run in the iterative divider.
// Reset: pc 0, sp and bp at 4096, accumulator 0, not running; memory is
// not cleared and holds nothing valid until written.
module stack_vm_core #(
  parameter int MEM_WORDS = svm_pkg::MEM_WORDS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  svm_pkg::in_t  in_item_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output svm_pkg::out_t out_item_o,
  input  logic          cfg_we_i,
  input  logic [12:0]   cfg_data_i
);
  import svm_pkg::*;

  localparam int AW = $clog2(MEM_WORDS);

  state_e      state_q, state_d;
  logic [1:0]  func_q, func_d;
  logic [11:0] addr_q, addr_d;
  logic [31:0] data_q, data_d;
  logic [11:0] pc_q, pc_d;
  logic [12:0] sp_q, sp_d, bp_q, bp_d, st_top_q, npc_q, npc_d;
  logic [31:0] ax_q, ax_d, imm_q, imm_d, w1_q, w1_d, rd_q, rd_d;
  logic        run_q, run_d;
  logic [2:0]  status_q, status_d;
  op_e         op_q, op_d;

  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [31:0]   mem_wdata, mem_rdata;
  logic [31:0]   alu_res, div_res, sp32, bp32, spm4, st32, t_ent, t_adj;
  logic          div_start, div_done, chk_ok, illegal;
  logic [4:0]    sh;
  logic [7:0]    lbyte;

  function automatic logic word_ok(logic [31:0] a);
    return (a[1:0] == 2'b00) && ({2'b00, a[31:2]} < 32'(MEM_WORDS));
  endfunction
  function automatic logic byte_ok(logic [31:0] a);
    return {2'b00, a[31:2]} < 32'(MEM_WORDS);
  endfunction
  function automatic logic code_ok(logic [31:0] a);
    return (a < 32'(CODE_LIMIT)) && word_ok(a);
  endfunction
  function automatic logic ptr_ok(logic [31:0] a);
    return (a[1:0] == 2'b00) && (a <= 32'(CODE_LIMIT));
  endfunction
  function automatic logic pop_ok(logic [31:0] a);
    return (a < 32'(CODE_LIMIT)) && word_ok(a);
  endfunction
  function automatic logic [AW-1:0] widx(logic [31:0] a);
    return a[AW+1:2];
  endfunction

  svm_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_ram (
    .clk_i, .we_i(mem_we), .addr_i(mem_addr), .wdata_i(mem_wdata), .rdata_o(mem_rdata)
  );

  svm_alu u_alu (.op_i(op_q), .l_i(mem_rdata), .r_i(ax_q), .res_o(alu_res));

  svm_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .rem_i(op_q == OP_MOD),
    .a_i(mem_rdata), .b_i(ax_q), .done_o(div_done), .res_o(div_res)
  );

  assign sp32  = {19'd0, sp_q};
  assign bp32  = {19'd0, bp_q};
  assign st32  = {19'd0, st_top_q};
  assign spm4  = sp32 - 32'd4;
  assign t_ent = spm4 - {imm_q[29:0], 2'b00};
  assign t_adj = sp32 + {imm_q[29:0], 2'b00};
  assign illegal = (mem_rdata > 32'd37) || (mem_rdata >= 32'd30 && mem_rdata <= 32'd36);
  assign sh    = {w1_q[1:0], 3'b000};
  assign lbyte = 8'(mem_rdata >> {ax_q[1:0], 3'b000});

  // Checks that decide whether a step continues or faults.
  always_comb begin
    chk_ok = 1'b1;
    unique case (state_q)
      S_DISP: begin
        case (func_q)
          FN_WRITE, FN_READ: chk_ok = word_ok({20'd0, addr_q});
          FN_START: chk_ok = (st32 >= 32'd12) && word_ok(st32 - 32'd4)
                             && word_ok(st32 - 32'd8) && word_ok(st32 - 32'd12)
                             && code_ok({20'd0, addr_q});
          default: chk_ok = run_q && code_ok({20'd0, pc_q});
        endcase
      end
      S_FETCH: chk_ok = !illegal && (mem_rdata > 32'd7 || code_ok({20'd0, pc_q} + 32'd4));
      S_EXEC: begin
        case (op_q)
          OP_JMP:  chk_ok = code_ok(imm_q);
          OP_CALL: chk_ok = code_ok(imm_q) && sp32 >= 32'd4 && word_ok(spm4);
          OP_JZ:   chk_ok = (ax_q != 32'd0) || code_ok(imm_q);
          OP_JNZ:  chk_ok = (ax_q == 32'd0) || code_ok(imm_q);
          OP_ENT:  chk_ok = sp32 >= 32'd4 && word_ok(spm4) && ptr_ok(t_ent);
          OP_ADJ:  chk_ok = ptr_ok(t_adj);
          OP_LEV:  chk_ok = pop_ok(bp32) && pop_ok(bp32 + 32'd4);
          OP_LI:   chk_ok = word_ok(ax_q);
          OP_LC:   chk_ok = byte_ok(ax_q);
          OP_PUSH: chk_ok = sp32 >= 32'd4 && word_ok(spm4);
          OP_LEA, OP_IMM: chk_ok = 1'b1;
          default: chk_ok = pop_ok(sp32);
        endcase
      end
      S_POP: begin
        case (op_q)
          OP_DIV, OP_MOD: chk_ok = ax_q != 32'd0;
          OP_SI: chk_ok = word_ok(mem_rdata);
          OP_SC: chk_ok = byte_ok(mem_rdata);
          default: chk_ok = 1'b1;
        endcase
      end
      S_LEV2: chk_ok = ptr_ok(w1_q) && code_ok(mem_rdata);
      default: chk_ok = 1'b1;
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_DISP;
      S_DISP: begin
        if (!chk_ok) state_d = S_OUT;
        else begin
          case (func_q)
            FN_WRITE: state_d = S_OUT;
            FN_READ:  state_d = S_RD;
            FN_START: state_d = S_ST1;
            default:  state_d = S_FETCH;
          endcase
        end
      end
      S_RD:    state_d = S_OUT;
      S_ST1:   state_d = S_ST2;
      S_ST2:   state_d = S_ST3;
      S_ST3:   state_d = S_OUT;
      S_FETCH: state_d = !chk_ok ? S_OUT : (mem_rdata <= 32'd7 ? S_IMM : S_EXEC);
      S_IMM:   state_d = S_EXEC;
      S_EXEC: begin
        if (!chk_ok) state_d = S_OUT;
        else begin
          case (op_q)
            OP_LEV:        state_d = S_LEV1;
            OP_LI, OP_LC:  state_d = S_LOAD;
            OP_LEA, OP_IMM, OP_JMP, OP_CALL, OP_JZ, OP_JNZ, OP_ENT, OP_ADJ,
            OP_PUSH:       state_d = S_OUT;
            default:       state_d = S_POP;
          endcase
        end
      end
      S_POP: begin
        if (!chk_ok) state_d = S_OUT;
        else if (op_q == OP_DIV || op_q == OP_MOD) state_d = S_DIV;
        else if (op_q == OP_SC) state_d = S_SCRD;
        else state_d = S_OUT;
      end
      S_LEV1:  state_d = S_LEV2;
      S_LEV2:  state_d = S_OUT;
      S_LOAD:  state_d = S_OUT;
      S_SCRD:  state_d = S_OUT;
      S_DIV:   if (div_done) state_d = S_OUT;
      S_OUT:   if (!out_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    func_d = func_q; addr_d = addr_q; data_d = data_q;
    pc_d = pc_q; sp_d = sp_q; bp_d = bp_q; ax_d = ax_q; run_d = run_q;
    npc_d = npc_q; imm_d = imm_q; w1_d = w1_q; rd_d = rd_q;
    status_d = status_q; op_d = op_q;
    mem_we = 1'b0; mem_addr = '0; mem_wdata = ax_q; div_start = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        func_d = in_item_i.func; addr_d = in_item_i.addr; data_d = in_item_i.data;
      end
      S_DISP: begin
        status_d = ST_OK; rd_d = '0;
        mem_addr = widx({20'd0, addr_q});
        case (func_q)
          FN_WRITE: begin
            if (chk_ok) begin mem_we = 1'b1; mem_wdata = data_q; end
            else status_d = ST_BADADDR;
          end
          FN_READ: if (!chk_ok) status_d = ST_BADADDR;
          FN_START: if (!chk_ok) begin status_d = ST_BADADDR; run_d = 1'b0; end
          default: begin
            mem_addr = widx({20'd0, pc_q});
            if (!run_q) status_d = ST_IDLE;
            else if (!chk_ok) begin status_d = ST_BADADDR; run_d = 1'b0; end
          end
        endcase
      end
      S_RD: rd_d = mem_rdata;
      S_ST1: begin
        mem_we = 1'b1; mem_addr = widx(st32 - 32'd4); mem_wdata = 32'(OP_EXIT);
      end
      S_ST2: begin
        mem_we = 1'b1; mem_addr = widx(st32 - 32'd8); mem_wdata = 32'(OP_PUSH);
      end
      S_ST3: begin
        mem_we = 1'b1; mem_addr = widx(st32 - 32'd12); mem_wdata = st32 - 32'd8;
        sp_d = st_top_q - 13'd12; bp_d = st_top_q; pc_d = addr_q;
        ax_d = '0; run_d = 1'b1;
      end
      S_FETCH: begin
        npc_d = {1'b0, pc_q} + 13'd4;
        imm_d = '0;
        op_d = op_e'(mem_rdata[5:0]);
        mem_addr = widx({20'd0, pc_q} + 32'd4);
        if (!chk_ok) begin
          status_d = illegal ? ST_ILL : ST_BADADDR;
          run_d = 1'b0;
        end
      end
      S_IMM: begin
        imm_d = mem_rdata; npc_d = npc_q + 13'd4;
      end
      S_EXEC: begin
        mem_addr = widx(sp32);
        if (!chk_ok) begin
          status_d = ST_BADADDR; run_d = 1'b0;
        end else begin
          case (op_q)
            OP_LEA: begin ax_d = bp32 + {imm_q[29:0], 2'b00}; pc_d = npc_q[11:0]; end
            OP_IMM: begin ax_d = imm_q; pc_d = npc_q[11:0]; end
            OP_JMP: pc_d = imm_q[11:0];
            OP_CALL: begin
              mem_we = 1'b1; mem_addr = widx(spm4); mem_wdata = {19'd0, npc_q};
              sp_d = spm4[12:0]; pc_d = imm_q[11:0];
            end
            OP_JZ:  pc_d = (ax_q == 32'd0) ? imm_q[11:0] : npc_q[11:0];
            OP_JNZ: pc_d = (ax_q != 32'd0) ? imm_q[11:0] : npc_q[11:0];
            OP_ENT: begin
              mem_we = 1'b1; mem_addr = widx(spm4); mem_wdata = bp32;
              bp_d = spm4[12:0]; sp_d = t_ent[12:0]; pc_d = npc_q[11:0];
            end
            OP_ADJ: begin sp_d = t_adj[12:0]; pc_d = npc_q[11:0]; end
            OP_PUSH: begin
              mem_we = 1'b1; mem_addr = widx(spm4);
              sp_d = spm4[12:0]; pc_d = npc_q[11:0];
            end
            OP_LEV: mem_addr = widx(bp32);
            OP_LI, OP_LC: mem_addr = widx(ax_q);
            default: ;
          endcase
        end
      end
      S_POP: begin
        w1_d = mem_rdata;
        mem_addr = widx(mem_rdata);
        case (op_q)
          OP_EXIT: begin
            rd_d = mem_rdata; status_d = ST_EXIT; run_d = 1'b0; pc_d = npc_q[11:0];
          end
          OP_DIV, OP_MOD: begin
            if (!chk_ok) begin status_d = ST_DIV0; run_d = 1'b0; end
            else div_start = 1'b1;
          end
          OP_SI: begin
            if (!chk_ok) begin status_d = ST_BADADDR; run_d = 1'b0; end
            else begin
              mem_we = 1'b1; sp_d = sp_q + 13'd4; pc_d = npc_q[11:0];
            end
          end
          OP_SC: if (!chk_ok) begin status_d = ST_BADADDR; run_d = 1'b0; end
          default: begin
            ax_d = alu_res; sp_d = sp_q + 13'd4; pc_d = npc_q[11:0];
          end
        endcase
      end
      S_LEV1: begin
        w1_d = mem_rdata; mem_addr = widx(bp32 + 32'd4);
      end
      S_LEV2: begin
        if (!chk_ok) begin status_d = ST_BADADDR; run_d = 1'b0; end
        else begin
          sp_d = bp_q + 13'd8; bp_d = w1_q[12:0]; pc_d = mem_rdata[11:0];
        end
      end
      S_LOAD: begin
        ax_d = (op_q == OP_LI) ? mem_rdata : {{24{lbyte[7]}}, lbyte};
        pc_d = npc_q[11:0];
      end
      S_SCRD: begin
        mem_we = 1'b1; mem_addr = widx(w1_q);
        mem_wdata = (mem_rdata & ~(32'hFF << sh)) | ({24'd0, ax_q[7:0]} << sh);
        ax_d = {{24{ax_q[7]}}, ax_q[7:0]};
        sp_d = sp_q + 13'd4; pc_d = npc_q[11:0];
      end
      S_DIV: begin
        if (div_done) begin
          ax_d = div_res; sp_d = sp_q + 13'd4; pc_d = npc_q[11:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      pc_q     <= '0;
      sp_q     <= STACK_TOP_RST;
      bp_q     <= STACK_TOP_RST;
      ax_q     <= '0;
      run_q    <= 1'b0;
      st_top_q <= STACK_TOP_RST;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      sp_q    <= sp_d;
      bp_q    <= bp_d;
      ax_q    <= ax_d;
      run_q   <= run_d;
      if (cfg_we_i) begin
        st_top_q <= (cfg_data_i > STACK_TOP_RST) ? STACK_TOP_RST
                                                 : {cfg_data_i[12:2], 2'b00};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    func_q <= func_d; addr_q <= addr_d; data_q <= data_d;
    npc_q <= npc_d; imm_q <= imm_d; w1_q <= w1_d; rd_q <= rd_d;
    status_q <= status_d; op_q <= op_d;
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = state_q == S_OUT;
  assign out_item_o  = '{status: status_q, accumulator_out: ax_q,
                         next_pc: pc_q, read_data: rd_q};

  a_idle_no_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !out_valid_o) else $error("result shown while idle");
  a_sp_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q[1:0] == 2'b00 && bp_q[1:0] == 2'b00) else $error("sp or bp unaligned");
  a_notrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status == ST_IDLE |-> !run_q)
    else $error("not-running status while running");
  a_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV) else $error("divider done outside divide");
endmodule
